>>> hw/rtl/stil_pkg.sv
// Shared types and constants for the sample table interpolation lookup.
// No dependencies.
package stil_pkg;

  localparam logic [1:0] CmdClear  = 2'd0;
  localparam logic [1:0] CmdAppend = 2'd1;
  localparam logic [1:0] CmdQuery  = 2'd2;

  // One stored sample, packed as a single memory row.
  typedef struct packed {
    logic [31:0]        delay;
    logic [31:0]        distance;
    logic [19:0]        impedance;
    logic [15:0]        permittivity;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic [23:0]        trace_width;
    logic [5:0]         layer_id;
  } sample_t;

  localparam int unsigned SampleW = $bits(sample_t);

endpackage

>>> hw/rtl/stil_ram.sv
// Generic single-port RAM with registered read.
// No dependencies.
module stil_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end

endmodule

>>> hw/rtl/stil_divider.sv
// Restoring divider, one quotient bit per cycle: (num << FracBits) / den.
// No dependencies; num < den is guaranteed by the caller.
module stil_divider #(
  parameter int unsigned FracBits = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic [31:0]         num_i,
  input  logic [31:0]         den_i,
  output logic                done_o,
  output logic [FracBits-1:0] quot_o
);

  localparam int unsigned CntW = $clog2(FracBits + 1);

  logic [32:0]         rem_q, rem_d;
  logic [31:0]         den_q;
  logic [FracBits-1:0] quot_q, quot_d;
  logic [CntW-1:0]     cnt_q;
  logic                busy_q;
  logic [32:0]         trial;

  always_comb begin
    trial  = {rem_q[31:0], 1'b0};
    rem_d  = trial;
    quot_d = {quot_q[FracBits-2:0], 1'b0};
    if (trial >= {1'b0, den_q}) begin
      rem_d  = trial - {1'b0, den_q};
      quot_d[0] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
      done_o <= 1'b0;
    end else begin
      done_o <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CntW'(FracBits);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CntW'(1)) begin
          busy_q <= 1'b0;
          done_o <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q  <= {1'b0, num_i};
      den_q  <= den_i;
      quot_q <= '0;
    end else if (busy_q) begin
      rem_q  <= rem_d;
      quot_q <= quot_d;
    end
  end

  assign quot_o = quot_q;

endmodule

>>> hw/rtl/stil_lerp.sv
// Shared interpolation unit: lo + trunc(frac * (hi - lo) >> FracBits).
// One field per use, registered result. No dependencies.
// The fraction carries one integer bit so that a weight of exactly one fits.
module stil_lerp #(
  parameter int unsigned FracBits = 16
) (
  input  logic                clk_i,
  input  logic signed [32:0]  lo_i,
  input  logic signed [32:0]  hi_i,
  input  logic [FracBits:0]   frac_i,
  output logic signed [32:0]  res_o
);

  localparam int unsigned ProdW = 35 + FracBits;

  logic signed [33:0]           diff;
  logic [33:0]                  mag;
  logic [ProdW-1:0]             prod;
  logic [33:0]                  step;

  always_comb begin
    diff = {hi_i[32], hi_i} - {lo_i[32], lo_i};
    mag  = diff[33] ? 34'(-diff) : 34'(diff);
    prod = ProdW'(mag) * ProdW'(frac_i);
    step = prod[FracBits+33:FracBits];
  end

  always_ff @(posedge clk_i) begin
    res_o <= diff[33] ? 33'({lo_i[32], lo_i} - $signed(step))
                      : 33'({lo_i[32], lo_i} + $signed(step));
  end

endmodule

>>> hw/rtl/sample_table_interp_lookup.sv
// Sample table interpolation lookup, top level.
// Depends on stil_pkg, stil_ram, stil_divider, stil_lerp.
//
// The binary search reads one row of the single-port table at a time, the
// divider produces one fraction bit per cycle, and one shared interpolation
// unit serves the six numeric fields in turn. A query on an empty table goes
// straight to the output register, and one that clamps to an end sample or
// lands exactly on a stored delay skips the divider. The block takes no new
// word until the current one is done and, for a query, its result has left
// the output register. Appends beyond the depth or below the last delay are
// dropped.
module sample_table_interp_lookup #(
  parameter int unsigned TABLE_DEPTH = 512,
  parameter int unsigned FRAC_BITS   = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  output logic               stall_o,
  input  logic [1:0]         command_i,
  input  logic [31:0]        delay_i,
  input  logic [31:0]        distance_i,
  input  logic [19:0]        impedance_i,
  input  logic [15:0]        permittivity_i,
  input  logic signed [31:0] pos_x_i,
  input  logic signed [31:0] pos_y_i,
  input  logic [23:0]        trace_width_i,
  input  logic [5:0]         layer_id_i,
  output logic               valid_o,
  input  logic               stall_i,
  output logic               found_o,
  output logic [31:0]        out_delay_o,
  output logic [31:0]        out_distance_o,
  output logic [19:0]        out_impedance_o,
  output logic [15:0]        out_permittivity_o,
  output logic signed [31:0] out_x_o,
  output logic signed [31:0] out_y_o,
  output logic [23:0]        out_width_o,
  output logic [5:0]         out_layer_o
);

  localparam int unsigned AddrW = $clog2(TABLE_DEPTH);
  localparam int unsigned CntW  = $clog2(TABLE_DEPTH + 1);

  typedef enum logic [4:0] {
    StIdle, StAppRd, StAppWait, StAppChk,
    StQFirst, StQFirstW, StQLast, StQLastW,
    StSrch, StSrchW, StRdHi, StRdHiW, StRdLo, StRdLoW,
    StDiv, StDivW, StLerp, StOut
  } state_e;

  state_e                      state_q;
  logic [CntW-1:0]             count_q;
  logic [CntW-1:0]             a_q, b_q;
  logic [CntW-1:0]             mid;
  logic [31:0]                 qd_q;
  stil_pkg::sample_t           in_q, lo_q, hi_q, ram_rd, ram_wr;
  logic                        ram_we;
  logic [AddrW-1:0]            ram_addr;
  logic                        div_start, div_done;
  logic [FRAC_BITS-1:0]        quot;
  logic [2:0]                  fld_q;
  logic signed [32:0]          lerp_lo, lerp_hi, lerp_res;
  logic [FRAC_BITS:0]          frac_q;

  assign mid = CntW'((a_q + b_q) >> 1);

  stil_ram #(.Width(stil_pkg::SampleW), .Depth(TABLE_DEPTH)) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (ram_wr),
    .rdata_o (ram_rd)
  );

  stil_divider #(.FracBits(FRAC_BITS)) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (qd_q - lo_q.delay),
    .den_i   (hi_q.delay - lo_q.delay),
    .done_o  (div_done),
    .quot_o  (quot)
  );

  always_comb begin
    lerp_lo = '0;
    lerp_hi = '0;
    case (fld_q)
      3'd0: begin
        lerp_lo = {1'b0, lo_q.distance};
        lerp_hi = {1'b0, hi_q.distance};
      end
      3'd1: begin
        lerp_lo = 33'({lo_q.impedance});
        lerp_hi = 33'({hi_q.impedance});
      end
      3'd2: begin
        lerp_lo = 33'({lo_q.permittivity});
        lerp_hi = 33'({hi_q.permittivity});
      end
      3'd3: begin
        lerp_lo = {lo_q.pos_x[31], lo_q.pos_x};
        lerp_hi = {hi_q.pos_x[31], hi_q.pos_x};
      end
      3'd4: begin
        lerp_lo = {lo_q.pos_y[31], lo_q.pos_y};
        lerp_hi = {hi_q.pos_y[31], hi_q.pos_y};
      end
      default: begin
        lerp_lo = 33'({lo_q.trace_width});
        lerp_hi = 33'({hi_q.trace_width});
      end
    endcase
  end

  stil_lerp #(.FracBits(FRAC_BITS)) u_lerp (
    .clk_i  (clk_i),
    .lo_i   (lerp_lo),
    .hi_i   (lerp_hi),
    .frac_i (frac_q),
    .res_o  (lerp_res)
  );

  always_comb begin
    ram_we    = 1'b0;
    ram_wr    = in_q;
    ram_addr  = '0;
    div_start = (state_q == StDiv);
    unique case (state_q)
      StAppRd, StAppWait: ram_addr = AddrW'(count_q - 1'b1);
      StAppChk: begin
        ram_addr = AddrW'(count_q);
        ram_we   = (count_q < CntW'(TABLE_DEPTH)) &&
                   (count_q == '0 || in_q.delay >= ram_rd.delay);
      end
      StQFirst, StQFirstW: ram_addr = '0;
      StQLast, StQLastW:   ram_addr = AddrW'(count_q - 1'b1);
      StSrch, StSrchW:     ram_addr = AddrW'(mid);
      StRdHi, StRdHiW:     ram_addr = AddrW'(a_q);
      StRdLo, StRdLoW:     ram_addr = AddrW'(a_q - 1'b1);
      default:             ram_addr = '0;
    endcase
  end

  assign stall_o = (state_q != StIdle);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      count_q <= '0;
      valid_o <= 1'b0;
      a_q     <= '0;
      b_q     <= '0;
      fld_q   <= '0;
    end else begin
      unique case (state_q)
        StIdle: begin
          if (valid_i) begin
            in_q <= '{delay_i, distance_i, impedance_i, permittivity_i,
                      pos_x_i, pos_y_i, trace_width_i, layer_id_i};
            qd_q <= delay_i;
            unique case (command_i)
              stil_pkg::CmdClear:  count_q <= '0;
              stil_pkg::CmdAppend: state_q <= StAppRd;
              stil_pkg::CmdQuery: begin
                if (count_q == '0) begin
                  found_o            <= 1'b0;
                  out_delay_o        <= '0;
                  out_distance_o     <= '0;
                  out_impedance_o    <= '0;
                  out_permittivity_o <= '0;
                  out_x_o            <= '0;
                  out_y_o            <= '0;
                  out_width_o        <= '0;
                  out_layer_o        <= '0;
                  valid_o            <= 1'b1;
                  state_q            <= StOut;
                end else begin
                  state_q <= StQFirst;
                end
              end
              default: ;
            endcase
          end
        end
        StAppRd:   state_q <= StAppWait;
        StAppWait: state_q <= StAppChk;
        StAppChk: begin
          if (ram_we) count_q <= count_q + 1'b1;
          state_q <= StIdle;
        end
        StQFirst:  state_q <= StQFirstW;
        StQFirstW: begin
          if (qd_q <= ram_rd.delay) begin
            // same row on both sides, so the span is zero
            lo_q    <= ram_rd;
            hi_q    <= ram_rd;
            qd_q    <= ram_rd.delay;
            frac_q  <= '0;
            state_q <= StLerp;
            fld_q   <= '0;
          end else begin
            state_q <= StQLast;
          end
        end
        StQLast:  state_q <= StQLastW;
        StQLastW: begin
          if (qd_q >= ram_rd.delay) begin
            lo_q    <= ram_rd;
            hi_q    <= ram_rd;
            qd_q    <= ram_rd.delay;
            frac_q  <= '0;
            fld_q   <= '0;
            state_q <= StLerp;
          end else begin
            a_q     <= '0;
            b_q     <= count_q;
            state_q <= StSrch;
          end
        end
        StSrch: state_q <= (a_q < b_q) ? StSrchW : StRdHi;
        StSrchW: begin
          if (ram_rd.delay < qd_q) a_q <= mid + 1'b1;
          else                     b_q <= mid;
          state_q <= StSrch;
        end
        StRdHi:  state_q <= StRdHiW;
        StRdHiW: begin
          hi_q    <= ram_rd;
          state_q <= StRdLo;
        end
        StRdLo:  state_q <= StRdLoW;
        StRdLoW: begin
          lo_q <= ram_rd;
          // query exactly on the upper delay: weight of one, skip the divider
          if (qd_q == hi_q.delay) begin
            frac_q  <= {1'b1, {FRAC_BITS{1'b0}}};
            fld_q   <= '0;
            state_q <= StLerp;
          end else begin
            state_q <= StDiv;
          end
        end
        StDiv: state_q <= StDivW;
        StDivW: begin
          if (div_done) begin
            frac_q  <= {1'b0, quot};
            fld_q   <= '0;
            state_q <= StLerp;
          end
        end
        StLerp: begin
          // result of the previous field lands in the cycle after its select
          fld_q <= fld_q + 1'b1;
          unique case (fld_q)
            3'd1: out_distance_o     <= lerp_res[31:0];
            3'd2: out_impedance_o    <= lerp_res[19:0];
            3'd3: out_permittivity_o <= lerp_res[15:0];
            3'd4: out_x_o            <= lerp_res[31:0];
            3'd5: out_y_o            <= lerp_res[31:0];
            3'd6: begin
              out_width_o <= lerp_res[23:0];
              found_o     <= 1'b1;
              out_delay_o <= qd_q;
              out_layer_o <= lo_q.layer_id;
              valid_o     <= 1'b1;
              state_q     <= StOut;
            end
            default: ;
          endcase
        end
        StOut: begin
          if (!stall_i) begin
            valid_o <= 1'b0;
            state_q <= StIdle;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_count_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(TABLE_DEPTH)) else $error("entry count overflow");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && stall_i |=> valid_o && $stable(out_delay_o))
    else $error("result dropped while stalled");
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> stall_o) else $error("input taken while result pending");
`endif

endmodule

>>> sim/tb.sv
// Testbench for sample_table_interp_lookup: drives clear, append and query words,
// predicts every lookup result with a shadow table and checks it field by field.
// Depends on stil_pkg and the RTL of sample_table_interp_lookup.
module tb;

  localparam int unsigned Depth    = 512;
  localparam int unsigned FracBits = 16;
  localparam logic [1:0]  CmdSpare = 2'd3;

  typedef struct {
    bit                drain;
    logic [1:0]        cmd;
    stil_pkg::sample_t s;
  } word_t;

  typedef struct {
    logic               found;
    logic [31:0]        delay;
    logic [31:0]        distance;
    logic [19:0]        impedance;
    logic [15:0]        permittivity;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic [23:0]        trace_width;
    logic [5:0]         layer_id;
  } lookup_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic valid_i = 1'b0;
  logic stall_i = 1'b1;
  logic [1:0] command_i = stil_pkg::CmdClear;
  logic [31:0] delay_i = '0, distance_i = '0;
  logic [19:0] impedance_i = '0;
  logic [15:0] permittivity_i = '0;
  logic signed [31:0] pos_x_i = '0, pos_y_i = '0;
  logic [23:0] trace_width_i = '0;
  logic [5:0] layer_id_i = '0;
  logic stall_o, valid_o, found_o;
  logic [31:0] out_delay_o, out_distance_o;
  logic [19:0] out_impedance_o;
  logic [15:0] out_permittivity_o;
  logic signed [31:0] out_x_o, out_y_o;
  logic [23:0] out_width_o;
  logic [5:0] out_layer_o;

  sample_table_interp_lookup uut (.*);

  always #10 clk_i = ~clk_i;

  word_t             pending_words[$];
  lookup_t           lookup_q[$];
  stil_pkg::sample_t shadow_table[Depth];
  int unsigned shadow_count = 0;
  int          errors = 0;
  int          n_sent = 0, n_checked = 0, n_query = 0, n_append = 0, n_full_drop = 0;

  task automatic report(string what, logic [63:0] got, logic [63:0] want);
    $display("tb: mismatch %s got %0h want %0h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  function automatic longint lerp_field(longint lo, longint hi, longint unsigned frac);
    longint d;
    longint unsigned mag, st;
    d   = hi - lo;
    mag = (d < 0) ? longint'(-d) : longint'(d);
    st  = (mag * frac) >> FracBits;
    return (d < 0) ? lo - longint'(st) : lo + longint'(st);
  endfunction

  function automatic lookup_t from_sample(stil_pkg::sample_t s);
    lookup_t r;
    r = '{1'b1, s.delay, s.distance, s.impedance, s.permittivity, s.pos_x, s.pos_y,
          s.trace_width, s.layer_id};
    return r;
  endfunction

  function automatic lookup_t predict_lookup(logic [31:0] q);
    lookup_t r;
    int unsigned a, b, mid, h, l;
    longint unsigned span, frac;
    stil_pkg::sample_t sl, sh;
    r = '{default: '0};
    if (shadow_count == 0) return r;
    if (q <= shadow_table[0].delay) return from_sample(shadow_table[0]);
    if (q >= shadow_table[shadow_count-1].delay)
      return from_sample(shadow_table[shadow_count-1]);
    a = 0;
    b = shadow_count;
    while (a < b) begin
      mid = (a + b) >> 1;
      if (shadow_table[mid].delay < q) a = mid + 1;
      else b = mid;
    end
    h = a;
    l = h - 1;
    sl = shadow_table[l];
    sh = shadow_table[h];
    span = longint'(sh.delay) - longint'(sl.delay);
    if (span == 0) return from_sample(sl);
    frac = ((longint'(q) - longint'(sl.delay)) << FracBits) / span;
    r.found        = 1'b1;
    r.delay        = q;
    r.distance     = 32'(lerp_field(longint'(sl.distance), longint'(sh.distance), frac));
    r.impedance    = 20'(lerp_field(longint'(sl.impedance), longint'(sh.impedance), frac));
    r.permittivity = 16'(lerp_field(longint'(sl.permittivity), longint'(sh.permittivity),
                                    frac));
    r.pos_x        = 32'(lerp_field(longint'($signed(sl.pos_x)), longint'($signed(sh.pos_x)),
                                    frac));
    r.pos_y        = 32'(lerp_field(longint'($signed(sl.pos_y)), longint'($signed(sh.pos_y)),
                                    frac));
    r.trace_width  = 24'(lerp_field(longint'(sl.trace_width), longint'(sh.trace_width), frac));
    r.layer_id     = sl.layer_id;
    return r;
  endfunction

  // Advance the shadow table for one accepted word.
  task automatic apply_word(word_t w);
    case (w.cmd)
      stil_pkg::CmdClear: shadow_count = 0;
      stil_pkg::CmdAppend: begin
        n_append++;
        if (shadow_count >= Depth) n_full_drop++;
        else if (shadow_count == 0 || w.s.delay >= shadow_table[shadow_count-1].delay) begin
          shadow_table[shadow_count] = w.s;
          shadow_count++;
        end
      end
      stil_pkg::CmdQuery: begin
        n_query++;
        lookup_q.insert(lookup_q.size(), predict_lookup(w.s.delay));
      end
      default: ;
    endcase
  endtask

  // Driver: per-word idle gap, drain markers hold until all results are back.
  int unsigned gap = 0;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_i <= 1'b0;
      gap     <= 0;
    end else begin
      if (valid_i && !stall_o) begin
        apply_word(word_t'{1'b0, command_i, stil_pkg::sample_t'{delay_i, distance_i,
          impedance_i, permittivity_i, pos_x_i, pos_y_i, trace_width_i, layer_id_i}});
        n_sent++;
      end
      if (!valid_i || !stall_o) begin
        if (gap > 0) begin
          gap     <= gap - 1;
          valid_i <= 1'b0;
        end else if (pending_words.size() > 0 && pending_words[0].drain) begin
          valid_i <= 1'b0;
          if (lookup_q.size() == 0) begin
            void'(pending_words.pop_front());
            gap <= 80;
          end
        end else if (pending_words.size() > 0) begin
          word_t w;
          w = pending_words.pop_front();
          valid_i        <= 1'b1;
          command_i      <= w.cmd;
          delay_i        <= w.s.delay;
          distance_i     <= w.s.distance;
          impedance_i    <= w.s.impedance;
          permittivity_i <= w.s.permittivity;
          pos_x_i        <= w.s.pos_x;
          pos_y_i        <= w.s.pos_y;
          trace_width_i  <= w.s.trace_width;
          layer_id_i     <= w.s.layer_id;
          gap <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 7);
        end else begin
          valid_i <= 1'b0;
        end
      end
    end
  end

  // Long receiver hold-off, once, while the sender keeps offering words.
  int unsigned hold = 0;
  bit hold_done = 0;
  always @(posedge clk_i) begin
    if (!hold_done && n_sent >= 300) begin
      hold      <= 600;
      hold_done <= 1;
    end else if (hold > 0) begin
      hold <= hold - 1;
    end
  end

  // Monitor: check each accepted result word, then draw the next stall.
  int unsigned rwait = 0;
  always @(posedge clk_i) begin
    int unsigned nw;
    lookup_t e;
    if (valid_o && !stall_i) begin
      n_checked++;
      if (lookup_q.size() == 0) begin
        report("unexpected word", 0, 0);
      end else begin
        e = lookup_q.pop_front();
        if (found_o !== e.found) report("found", found_o, e.found);
        if (out_delay_o !== e.delay) report("delay", out_delay_o, e.delay);
        if (out_distance_o !== e.distance) report("distance", out_distance_o, e.distance);
        if (out_impedance_o !== e.impedance)
          report("impedance", out_impedance_o, e.impedance);
        if (out_permittivity_o !== e.permittivity)
          report("permittivity", out_permittivity_o, e.permittivity);
        if (out_x_o !== e.pos_x) report("x", out_x_o, e.pos_x);
        if (out_y_o !== e.pos_y) report("y", out_y_o, e.pos_y);
        if (out_width_o !== e.trace_width) report("width", out_width_o, e.trace_width);
        if (out_layer_o !== e.layer_id) report("layer", out_layer_o, e.layer_id);
      end
      nw = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 7);
    end else begin
      nw = (rwait > 0) ? rwait - 1 : 0;
    end
    rwait   <= nw;
    stall_i <= (nw != 0) || (hold != 0);
  end

  function automatic stil_pkg::sample_t rand_sample(logic [31:0] d);
    stil_pkg::sample_t s;
    s = '{d, $urandom, 20'($urandom), 16'($urandom), $urandom, $urandom, 24'($urandom),
          6'($urandom)};
    return s;
  endfunction

  task automatic add(logic [1:0] cmd, stil_pkg::sample_t s);
    pending_words.insert(pending_words.size(), word_t'{1'b0, cmd, s});
  endtask

  task automatic add_drain();
    pending_words.insert(pending_words.size(),
                         word_t'{1'b1, stil_pkg::CmdClear, stil_pkg::sample_t'('0)});
  endtask

  // Clear (mostly), append a mostly sorted run, then query inside and around it.
  task automatic add_sequence(int unsigned n_samples, int unsigned n_queries);
    logic [31:0] d, first, last, step_max;
    longint unsigned nd;
    int unsigned pick;
    if ($urandom_range(0, 4) != 0) add(stil_pkg::CmdClear, rand_sample($urandom));
    step_max = ($urandom_range(0, 1) == 0) ? 32'd64 : ($urandom >> $urandom_range(0, 31));
    d = ($urandom_range(0, 3) == 0) ? 32'(($urandom_range(0, 3))) : ($urandom >> 1);
    first = d;
    for (int i = 0; i < n_samples; i++) begin
      if ($urandom_range(0, 19) == 0) add(stil_pkg::CmdAppend, rand_sample($urandom));
      else add(stil_pkg::CmdAppend, rand_sample(d));
      last = d;
      nd = longint'(d) + $urandom_range(0, 3) * (step_max / 3);
      d = (nd > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : 32'(nd);
    end
    for (int i = 0; i < n_queries; i++) begin
      pick = $urandom_range(0, 9);
      if (pick < 5 && last > first)
        add(stil_pkg::CmdQuery,
            rand_sample(first + 32'($urandom % (longint'(last) - first + 1))));
      else if (pick < 7)
        add(stil_pkg::CmdQuery, rand_sample(($urandom_range(0, 1) == 0) ? first : last));
      else if (pick < 8)
        add(stil_pkg::CmdQuery, rand_sample(first - 32'($urandom_range(0, 3))));
      else if (pick < 9)
        add(stil_pkg::CmdQuery, rand_sample(last + 32'($urandom_range(0, 3))));
      else add($urandom_range(0, 7) == 0 ? CmdSpare : stil_pkg::CmdQuery,
               rand_sample($urandom));
    end
  endtask

  initial begin
    #50_000_000;
    $display("tb: timeout");
    $display("tb: FAIL");
    $finish;
  end

  initial begin
    stil_pkg::sample_t hi_s, lo_s;
    hi_s = '{32'd0, '1, '1, '1, 32'sh8000_0000, 32'sh7FFF_FFFF, '1, 6'd63};
    lo_s = '{32'd1000, '0, '0, '0, 32'sh7FFF_FFFF, 32'sh8000_0000, '0, 6'd0};
    // Directed: empty table, spare command, extremes, clamping, drops, clear.
    add(stil_pkg::CmdQuery, rand_sample(32'd5));
    pending_words.insert(pending_words.size(), word_t'{1'b0, CmdSpare, '1});
    add(stil_pkg::CmdAppend, hi_s);
    add(stil_pkg::CmdAppend, lo_s);
    add(stil_pkg::CmdQuery, rand_sample(32'd0));
    add(stil_pkg::CmdQuery, rand_sample(32'd1000));
    add(stil_pkg::CmdQuery, rand_sample(32'd1));
    add(stil_pkg::CmdQuery, rand_sample(32'd500));
    add(stil_pkg::CmdQuery, rand_sample(32'd999));
    add(stil_pkg::CmdAppend, rand_sample(32'd5));
    add(stil_pkg::CmdAppend, rand_sample(32'd1000));
    add(stil_pkg::CmdQuery, rand_sample(32'd1000));
    add(stil_pkg::CmdAppend, '{32'hFFFF_FFFF, '0, '1, '0, 32'sh7FFF_FFFF, 32'sh0, '1, 6'd21});
    add(stil_pkg::CmdQuery, rand_sample(32'hFFFF_FFFE));
    add(stil_pkg::CmdQuery, rand_sample(32'hFFFF_FFFF));
    add(stil_pkg::CmdQuery, rand_sample(32'h8000_0000));
    add(stil_pkg::CmdClear, '1);
    add(stil_pkg::CmdQuery, rand_sample(32'hFFFF_FFFF));
    add_drain();
    // Full table: extra appends must drop.
    add_sequence(Depth + 4, 12);
    add_drain();
    while (pending_words.size() < 950) begin
      if ($urandom_range(0, 9) == 0) add(2'($urandom_range(0, 3)), rand_sample($urandom));
      else add_sequence($urandom_range(1, 12), $urandom_range(1, 8));
      if ($urandom_range(0, 15) == 0) add_drain();
    end
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    wait (pending_words.size() == 0 && !valid_i);
    wait (lookup_q.size() == 0);
    repeat (100) @(posedge clk_i);
    $display("tb: %0d words sent, %0d appends (%0d dropped on full table)", n_sent, n_append,
             n_full_drop);
    $display("tb: %0d queries, %0d results checked, %0d mismatches", n_query, n_checked,
             errors);
    if (errors == 0 && lookup_q.size() == 0) $display("tb: PASS");
    else $display("tb: FAIL");
    $finish;
  end

endmodule
